// File: design/lfp_pkg.sv
package lfp_pkg;

   localparam int COORD_WIDTH_DEFAULT = 24;
   localparam int AXIS_FRAC_DEFAULT = 14;
   localparam int LIMB_WIDTH = 24;
   localparam int OUT_WIDTH = 16;
   localparam int STATUS_WIDTH = 2;
   localparam int RSP_DATA_WIDTH = 9 * OUT_WIDTH;

   localparam logic [STATUS_WIDTH-1:0] ST_OK = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_MISSING = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_DEGENERATE = 2'd2;

   function automatic int mul_lat(input int aw, input int bw);
      return ((aw + LIMB_WIDTH - 1) / LIMB_WIDTH) * ((bw + LIMB_WIDTH - 1) / LIMB_WIDTH) + 2;
   endfunction

   function automatic int norm_lat(input int xw, input int f);
      return mul_lat(xw, xw) + 1 + (2 * f + 3) + (f + 2) + 1;
   endfunction

endpackage

// File: design/lfp_mul.sv
module lfp_mul #(
   parameter int AW = 26,
   parameter int BW = 51
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [AW-1:0]  a,
   input  logic signed [BW-1:0]  b,
   output logic signed [AW+BW-1:0] p
);

   localparam int LW = lfp_pkg::LIMB_WIDTH;
   localparam int NA = (AW + LW - 1) / LW;
   localparam int NB = (BW + LW - 1) / LW;
   localparam int NS = NA * NB;
   localparam int PW = AW + BW;
   localparam int AP = NA * LW;
   localparam int BP = NB * LW;

   logic [AW-1:0] am_ff [0:NS];
   logic [BW-1:0] bm_ff [0:NS];
   logic          neg_ff [0:NS];
   logic [PW-1:0] acc_ff [0:NS];
   logic [PW-1:0] p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         am_ff[0] <= a[AW-1] ? AW'(-a) : AW'(a);
         bm_ff[0] <= b[BW-1] ? BW'(-b) : BW'(b);
         neg_ff[0] <= a[AW-1] ^ b[BW-1];
         acc_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= NS; k++) begin : g_step
      localparam int I = (k - 1) / NB;
      localparam int J = (k - 1) % NB;
      logic [AP-1:0]   ap;
      logic [BP-1:0]   bp;
      logic [2*LW-1:0] prod;
      assign ap = AP'(am_ff[k-1]);
      assign bp = BP'(bm_ff[k-1]);
      assign prod = ap[I*LW +: LW] * bp[J*LW +: LW];
      always_ff @(posedge clock) begin
         if (en) begin
            am_ff[k] <= am_ff[k-1];
            bm_ff[k] <= bm_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            acc_ff[k] <= acc_ff[k-1] + (PW'(prod) << (LW * (I + J)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= neg_ff[NS] ? -acc_ff[NS] : acc_ff[NS];
      end
   end

   assign p = $signed(p_ff);

endmodule

// File: design/lfp_norm.sv
module lfp_norm #(
   parameter int XW = 26,
   parameter int F = 14,
   parameter int LAT = 80
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic signed [XW-1:0]  x [3],
   output logic [lfp_pkg::OUT_WIDTH-1:0] q [3],
   output logic                  zero
);

   localparam int OW = lfp_pkg::OUT_WIDTH;
   localparam int MLAT = lfp_pkg::mul_lat(XW, XW);
   localparam int SW = 2 * XW + 2;
   localparam int QW = 2 * F + 3;
   localparam int RW = F + 2;
   localparam int L2 = QW + RW;
   localparam int EW = (RW > OW) ? RW : OW;
   localparam int OWN = MLAT + 1 + QW + RW + 1;
   localparam int PAD = LAT - OWN;

   logic signed [2*XW-1:0] sq [3];
   logic          sgn_ff [3][0:MLAT-1];
   logic [SW-1:0] s_ff [0:QW];
   logic          zc_ff [0:L2];
   logic          sgc_ff [3][0:L2];
   logic [SW-1:0] r_ff [3][0:QW];
   logic [QW-1:0] nq_ff [3][0:QW];
   logic [QW+1:0] rm_ff [3][1:RW];
   logic [RW-1:0] rs_ff [3][1:RW];
   logic [OW-1:0] q_ff [3];
   logic          zf_ff;

   for (genvar c = 0; c < 3; c++) begin : g_sq
      lfp_mul #(.AW(XW), .BW(XW)) u_sq (
         .clock(clock), .en(en), .a(x[c]), .b(x[c]), .p(sq[c])
      );
      always_ff @(posedge clock) begin
         if (en) begin
            sgn_ff[c][0] <= x[c][XW-1];
            for (int k = 1; k < MLAT; k++) begin
               sgn_ff[c][k] <= sgn_ff[c][k-1];
            end
            sgc_ff[c][0] <= sgn_ff[c][MLAT-1];
            r_ff[c][0] <= SW'($unsigned(sq[c]));
            nq_ff[c][0] <= '0;
            for (int k = 1; k <= L2; k++) begin
               sgc_ff[c][k] <= sgc_ff[c][k-1];
            end
         end
      end
   end

   logic [SW-1:0] sum;
   assign sum = SW'($unsigned(sq[0])) + SW'($unsigned(sq[1])) + SW'($unsigned(sq[2]));

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff[0] <= sum;
         zc_ff[0] <= (sum == '0);
         for (int k = 1; k <= QW; k++) begin
            s_ff[k] <= s_ff[k-1];
         end
         for (int k = 1; k <= L2; k++) begin
            zc_ff[k] <= zc_ff[k-1];
         end
      end
   end

   // Long division: x*x * 2^(2F+2) / S, one quotient bit per stage.
   for (genvar d = 1; d <= QW; d++) begin : g_div
      for (genvar c = 0; c < 3; c++) begin : g_c
         logic [SW:0] rw;
         logic [SW:0] sv;
         logic        ge;
         if (d == 1) begin : g_first
            assign rw = (SW+1)'(r_ff[c][0]);
         end else begin : g_next
            assign rw = {r_ff[c][d-1], 1'b0};
         end
         assign sv = (SW+1)'(s_ff[d-1]);
         assign ge = (rw >= sv);
         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[c][d] <= SW'(ge ? rw - sv : rw);
               nq_ff[c][d] <= {nq_ff[c][d-1][QW-2:0], ge};
            end
         end
      end
   end

   // Integer square root of the quotient, one result bit per stage.
   for (genvar e = 1; e <= RW; e++) begin : g_sqrt
      localparam int K = RW - e;
      for (genvar c = 0; c < 3; c++) begin : g_c
         logic [QW+1:0] rin;
         logic [QW+1:0] t;
         logic [RW-1:0] resin;
         logic          ge;
         if (e == 1) begin : g_first
            assign rin = (QW+2)'(nq_ff[c][QW]);
            assign resin = '0;
         end else begin : g_next
            assign rin = rm_ff[c][e-1];
            assign resin = rs_ff[c][e-1];
         end
         assign t = ((QW+2)'(resin) << (K + 1)) + ((QW+2)'(1) << (2 * K));
         assign ge = (rin >= t);
         always_ff @(posedge clock) begin
            if (en) begin
               rm_ff[c][e] <= ge ? rin - t : rin;
               rs_ff[c][e] <= ge ? (resin | (RW'(1) << K)) : resin;
            end
         end
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_out
      logic [RW:0]   inc;
      logic [EW-1:0] qe;
      logic [EW-1:0] qo;
      assign inc = (RW+1)'(rs_ff[c][RW]) + (RW+1)'(1);
      assign qe = EW'(inc[RW:1]);
      assign qo = sgc_ff[c][L2] ? -qe : qe;
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[c] <= qo[OW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zf_ff <= zc_ff[L2];
      end
   end

   if (PAD > 0) begin : g_pad
      logic [OW-1:0] qp_ff [3][0:PAD-1];
      logic          zp_ff [0:PAD-1];
      always_ff @(posedge clock) begin
         if (en) begin
            for (int c = 0; c < 3; c++) begin
               qp_ff[c][0] <= q_ff[c];
               for (int k = 1; k < PAD; k++) begin
                  qp_ff[c][k] <= qp_ff[c][k-1];
               end
            end
            zp_ff[0] <= zf_ff;
            for (int k = 1; k < PAD; k++) begin
               zp_ff[k] <= zp_ff[k-1];
            end
         end
      end
      for (genvar c = 0; c < 3; c++) begin : g_q
         assign q[c] = qp_ff[c][PAD-1];
      end
      assign zero = zp_ff[PAD-1];
   end else begin : g_nopad
      for (genvar c = 0; c < 3; c++) begin : g_q
         assign q[c] = q_ff[c];
      end
      assign zero = zf_ff;
   end

endmodule

// File: design/local_frame_from_three_points.sv
// Builds a local orthonormal frame from three points A, B, C: with a = B - A and
// b = C - B, axis 2 is a - b, axis 0 is b x a and axis 1 is axis 2 x axis 0, each
// scaled to unit length and rounded to nearest (ties away from zero) in Q2.F.
// The block is a pipeline that accepts one item every cycle unless a result
// waits untaken at the output; each item passes through the limb-by-limb
// multipliers, the bit-per-stage divider and the bit-per-stage square root.
// When the result is not taken, the whole pipeline holds. A missing point gives
// status 1 and zero axes; a zero-length axis gives status 2 and zero axes.
module local_frame_from_three_points #(
   parameter int COORD_WIDTH = lfp_pkg::COORD_WIDTH_DEFAULT,
   parameter int AXIS_FRAC_BITS = lfp_pkg::AXIS_FRAC_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // point_a_x, point_a_y, point_a_z, point_b_x .. point_c_z, zero padded to bytes
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // point_missing
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // axis0_x, axis0_y, axis0_z, axis1_x .. axis2_z
   output logic [lfp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   // frame_status
   output logic [lfp_pkg::STATUS_WIDTH-1:0] rsp_tuser
);

   localparam int CW = COORD_WIDTH;
   localparam int F = AXIS_FRAC_BITS;
   localparam int OW = lfp_pkg::OUT_WIDTH;
   localparam int D1 = CW + 1;
   localparam int X2W = CW + 2;
   localparam int X0W = 2 * D1 + 1;
   localparam int X1W = X2W + X0W + 1;
   localparam int LM1 = lfp_pkg::mul_lat(X2W, X0W);
   localparam int LATN = lfp_pkg::norm_lat(X1W, F);
   localparam int K = 4 + LM1 + LATN;

   logic en;
   logic v_ff [0:K];
   logic miss_ff [0:K];

   logic signed [CW-1:0]      pa_ff [3];
   logic signed [CW-1:0]      pb_ff [3];
   logic signed [CW-1:0]      pc_ff [3];
   logic signed [D1-1:0]      a_ff [3];
   logic signed [D1-1:0]      b_ff [3];
   logic signed [X2W-1:0]     ax2_ff [3][1:3];
   logic signed [2*D1-1:0]    pr_ff [3][2];
   logic signed [X0W-1:0]     ax0_ff [3];
   logic signed [X2W+X0W-1:0] m1 [3][2];
   logic signed [X1W-1:0]     ax1_ff [3];
   logic signed [X0W-1:0]     x0d_ff [3][0:LM1];
   logic signed [X2W-1:0]     x2d_ff [3][0:LM1];
   logic signed [X0W-1:0]     n0_x [3];
   logic signed [X1W-1:0]     n1_x [3];
   logic signed [X2W-1:0]     n2_x [3];
   logic [OW-1:0] q0 [3];
   logic [OW-1:0] q1 [3];
   logic [OW-1:0] q2 [3];
   logic z0, z1, z2;
   logic [lfp_pkg::STATUS_WIDTH-1:0] status;

   assign en = !v_ff[K] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= K; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= req_tvalid;
         for (int k = 1; k <= K; k++) begin
            v_ff[k] <= v_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         miss_ff[0] <= req_tuser;
         for (int k = 1; k <= K; k++) begin
            miss_ff[k] <= miss_ff[k-1];
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_axis
      localparam int U = (g + 1) % 3;
      localparam int W = (g + 2) % 3;
      logic signed [D1-1:0] a_in;
      logic signed [D1-1:0] b_in;
      assign a_in = D1'(pb_ff[g]) - D1'(pa_ff[g]);
      assign b_in = D1'(pc_ff[g]) - D1'(pb_ff[g]);

      always_ff @(posedge clock) begin
         if (en) begin
            pa_ff[g] <= req_tdata[CW*g +: CW];
            pb_ff[g] <= req_tdata[CW*(3+g) +: CW];
            pc_ff[g] <= req_tdata[CW*(6+g) +: CW];
            a_ff[g] <= a_in;
            b_ff[g] <= b_in;
            ax2_ff[g][1] <= X2W'(a_in) - X2W'(b_in);
            ax2_ff[g][2] <= ax2_ff[g][1];
            ax2_ff[g][3] <= ax2_ff[g][2];
            pr_ff[g][0] <= b_ff[U] * a_ff[W];
            pr_ff[g][1] <= b_ff[W] * a_ff[U];
            ax0_ff[g] <= X0W'(pr_ff[g][0]) - X0W'(pr_ff[g][1]);
            ax1_ff[g] <= X1W'(m1[g][0]) - X1W'(m1[g][1]);
            x0d_ff[g][0] <= ax0_ff[g];
            x2d_ff[g][0] <= ax2_ff[g][3];
            for (int k = 1; k <= LM1; k++) begin
               x0d_ff[g][k] <= x0d_ff[g][k-1];
               x2d_ff[g][k] <= x2d_ff[g][k-1];
            end
         end
      end

      lfp_mul #(.AW(X2W), .BW(X0W)) u_mul_p (
         .clock(clock), .en(en), .a(ax2_ff[U][3]), .b(ax0_ff[W]), .p(m1[g][0])
      );
      lfp_mul #(.AW(X2W), .BW(X0W)) u_mul_n (
         .clock(clock), .en(en), .a(ax2_ff[W][3]), .b(ax0_ff[U]), .p(m1[g][1])
      );

      assign n0_x[g] = x0d_ff[g][LM1];
      assign n1_x[g] = ax1_ff[g];
      assign n2_x[g] = x2d_ff[g][LM1];
   end

   lfp_norm #(.XW(X0W), .F(F), .LAT(LATN)) u_norm0 (
      .clock(clock), .en(en), .x(n0_x), .q(q0), .zero(z0)
   );
   lfp_norm #(.XW(X1W), .F(F), .LAT(LATN)) u_norm1 (
      .clock(clock), .en(en), .x(n1_x), .q(q1), .zero(z1)
   );
   lfp_norm #(.XW(X2W), .F(F), .LAT(LATN)) u_norm2 (
      .clock(clock), .en(en), .x(n2_x), .q(q2), .zero(z2)
   );

   always_comb begin
      priority if (miss_ff[K]) begin
         status = lfp_pkg::ST_MISSING;
      end else if (z0 || z1 || z2) begin
         status = lfp_pkg::ST_DEGENERATE;
      end else begin
         status = lfp_pkg::ST_OK;
      end
   end

   assign rsp_tvalid = v_ff[K];
   assign rsp_tuser = status;
   assign rsp_tdata = (status == lfp_pkg::ST_OK) ?
      {q2[2], q2[1], q2[0], q1[2], q1[1], q1[0], q0[2], q0[1], q0[0]} : '0;

endmodule

// File: design/lfp_chk.sv
module lfp_chk (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [lfp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic [lfp_pkg::STATUS_WIDTH-1:0] rsp_tuser
);

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == lfp_pkg::ST_OK || rsp_tuser == lfp_pkg::ST_MISSING ||
                      rsp_tuser == lfp_pkg::ST_DEGENERATE))
      else $error("frame status out of range");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != lfp_pkg::ST_OK) |-> (rsp_tdata == '0))
      else $error("axes not cleared on a failed frame");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled item changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("item valid after reset");

endmodule

bind local_frame_from_three_points lfp_chk u_lfp_chk (.*);

// File: sim/frame_checker.sv
module frame_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [215:0] req_tdata,
   input  logic req_tuser,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [lfp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic [lfp_pkg::STATUS_WIDTH-1:0] rsp_tuser,
   output int errors,
   output int outstanding
);

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic [15:0] comp[9];
      logic [1:0] status;
   } frame_type;

   localparam int FRAC = 14;

   frame_type frames_due[$];

   function automatic logic [15:0] unit_component(input wide_type x, input wide_type s);
      logic [255:0] mag, rhs, lhs;
      logic [31:0] lo, hi, mid, d;
      logic neg;
      neg = x < 0;
      mag = neg ? -x : x;
      rhs = mag * mag * (256'd4 << (2 * FRAC));
      lo = 0;
      hi = 32'd1 << FRAC;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         d = 2 * mid - 1;
         lhs = 256'(d) * 256'(d) * 256'(s);
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return neg ? 16'(-lo) : 16'(lo);
   endfunction

   function automatic frame_type build_frame(input logic [215:0] data, input logic missing);
      frame_type f;
      wide_type p[9];
      wide_type a[3], b[3], ax[3][3], len[3];
      for (int k = 0; k < 9; k++) f.comp[k] = '0;
      if (missing) begin
         f.status = lfp_pkg::ST_MISSING;
         return f;
      end
      for (int k = 0; k < 9; k++) p[k] = $signed(data[24*k +: 24]);
      for (int i = 0; i < 3; i++) begin
         a[i] = p[3+i] - p[i];
         b[i] = p[6+i] - p[3+i];
         ax[2][i] = a[i] - b[i];
      end
      ax[0][0] = b[1] * a[2] - b[2] * a[1];
      ax[0][1] = b[2] * a[0] - b[0] * a[2];
      ax[0][2] = b[0] * a[1] - b[1] * a[0];
      ax[1][0] = ax[2][1] * ax[0][2] - ax[2][2] * ax[0][1];
      ax[1][1] = ax[2][2] * ax[0][0] - ax[2][0] * ax[0][2];
      ax[1][2] = ax[2][0] * ax[0][1] - ax[2][1] * ax[0][0];
      for (int i = 0; i < 3; i++)
         len[i] = ax[i][0] * ax[i][0] + ax[i][1] * ax[i][1] + ax[i][2] * ax[i][2];
      if (len[0] == 0 || len[1] == 0 || len[2] == 0) begin
         f.status = lfp_pkg::ST_DEGENERATE;
         return f;
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            f.comp[3*i+j] = unit_component(ax[i][j], len[i]);
      f.status = lfp_pkg::ST_OK;
      return f;
   endfunction

   initial begin
      errors = 0;
      outstanding = 0;
   end

   always @(posedge clock) begin
      frame_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) frames_due.push_back(build_frame(req_tdata, req_tuser));
         if (rsp_tvalid && rsp_tready) begin
            if (frames_due.size() == 0) begin
               $error("result item with no expectation waiting");
               errors++;
            end else begin
               want = frames_due.pop_front();
               for (int k = 0; k < 9; k++)
                  if (rsp_tdata[16*k +: 16] !== want.comp[k]) begin
                     $error("axis%0d_%s expected %0d actual %0d", k / 3,
                            (k % 3 == 0) ? "x" : (k % 3 == 1) ? "y" : "z",
                            $signed(want.comp[k]), $signed(rsp_tdata[16*k +: 16]));
                     errors++;
                  end
               if (rsp_tuser !== want.status) begin
                  $error("frame_status expected %0d actual %0d", want.status, rsp_tuser);
                  errors++;
               end
            end
         end
         outstanding = frames_due.size();
      end
   end
endmodule

// File: sim/tb_local_frame_from_three_points.sv
module tb_local_frame_from_three_points;

   localparam int IDLE_LIMIT = 4000;
   localparam int MAX_C = 8388607;
   localparam int MIN_C = -8388608;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [215:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [lfp_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic [lfp_pkg::STATUS_WIDTH-1:0] rsp_tuser;
   int errors, outstanding;
   int idle_cycles = 0;
   int sent = 0, n_missing = 0, n_line = 0;
   bit calm = 0;

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   local_frame_from_three_points dut (.*);

   frame_checker u_checker (.*);

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("stalled for %0d cycles", IDLE_LIMIT);
         $display("tb_local_frame_from_three_points: errors");
         $finish;
      end
   end

   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_tready <= 0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_points(input int p[9], input bit missing);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      for (int k = 0; k < 9; k++) req_tdata[24*k +: 24] <= p[k][23:0];
      req_tuser <= missing;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent++;
      if (missing) n_missing++;
   endtask

   function automatic int any_coord();
      return $signed($urandom_range(0, 32'hFFFFFF) << 8) >>> 8;
   endfunction

   task automatic send_line(input int near);
      int p[9];
      int d, s;
      s = $signed($urandom_range(0, 6)) - 3;
      for (int i = 0; i < 3; i++) begin
         d = $signed($urandom_range(0, 2 * near)) - near;
         p[i] = $signed($urandom_range(0, 2000000)) - 1000000;
         p[3+i] = p[i] + d;
         p[6+i] = p[3+i] + s * d;
      end
      n_line++;
      send_points(p, 0);
   endtask

   initial begin
      int p[9];
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Extremes of the coordinates and the missing flag.
      calm = 1;
      p = '{MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C, MAX_C, MIN_C, MAX_C};
      send_points(p, 0);
      p = '{MIN_C, MAX_C, MIN_C, MAX_C, MIN_C, MIN_C, MIN_C, MIN_C, MAX_C};
      send_points(p, 0);
      p = '{MIN_C, 0, 0, MAX_C, 0, 0, 0, MAX_C, 0};
      send_points(p, 0);
      p = '{0, MIN_C, MAX_C, MAX_C, 0, MIN_C, MIN_C, MAX_C, 0};
      send_points(p, 0);
      send_points(p, 1);
      p = '{MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C};
      send_points(p, 1);
      send_points(p, 0);
      p = '{MIN_C, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C};
      send_points(p, 0);
      // Degenerate frames: collinear points, a equal to b, a or b zero.
      p = '{0, 0, 0, 5, 7, -3, 10, 14, -6};
      send_points(p, 0);
      p = '{0, 0, 0, 5, 7, -3, -10, -14, 6};
      send_points(p, 0);
      p = '{1, 2, 3, 1, 2, 3, 9, 8, 7};
      send_points(p, 0);
      p = '{1, 2, 3, 9, 8, 7, 9, 8, 7};
      send_points(p, 0);
      p = '{-4, 4, 0, 0, 0, 0, 4, -4, 0};
      send_points(p, 0);
      // Small right-angle and near-tie frames.
      p = '{0, 0, 0, 1, 0, 0, 1, 1, 0};
      send_points(p, 0);
      p = '{0, 0, 0, 0, 1, 0, 0, 1, 1};
      send_points(p, 0);
      p = '{0, 0, 0, 3, 4, 0, 3, 4, 12};
      send_points(p, 0);
      p = '{1, -1, 0, 0, 0, 0, 1, 1, 1};
      send_points(p, 0);
      calm = 0;

      for (int n = 0; n < 1340; n++) begin
         if (n % 200 == 100) calm = ~calm;
         if (n == 700) begin
            req_tvalid <= 0;
            @(negedge clock);
            while (outstanding != 0) @(negedge clock);
         end
         case ($urandom_range(0, 9))
            0: send_line(3);
            1: send_line(100000);
            2: begin
               for (int k = 0; k < 9; k++) p[k] = any_coord();
               send_points(p, 1);
            end
            3, 4: begin
               for (int k = 0; k < 9; k++) p[k] = $signed($urandom_range(0, 16)) - 8;
               send_points(p, 0);
            end
            default: begin
               for (int k = 0; k < 9; k++) p[k] = any_coord();
               send_points(p, 0);
            end
         endcase
      end
      req_tvalid <= 0;

      while (outstanding != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("Sent %0d point triples: %0d with a missing point, %0d built collinear,",
               sent, n_missing, n_line);
      $display("the rest full-range and small-range coordinates under random stalls.");
      if (errors == 0) $display("tb_local_frame_from_three_points: clean");
      else $display("tb_local_frame_from_three_points: errors");
      $finish;
   end
endmodule
